>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QSED_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QSED_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/qsed_pkg.sv
// Types, codes and character helpers of the quoted string escape decoder.
package qsed_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX1  = 2'd2,
    MODE_HEX2  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_BYTE   = 2'd0,
    ST_CLOSED = 2'd1,
    ST_PREMAT = 2'd2,
    ST_BADHEX = 2'd3
  } status_e;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChUpperX    = 8'h58;

  // Item held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } item_t;

  // Result handed from the decoder to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    status_e    status;
  } res_t;

  // Bit 4 set: not a hex digit; else bits 3:0 hold the digit value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end
    return v;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h6e:   r = 8'h0a; // n
      8'h72:   r = 8'h0d; // r
      8'h62:   r = 8'h08; // b
      8'h65:   r = 8'h1b; // e
      8'h61:   r = 8'h07; // a
      8'h74:   r = 8'h09; // t
      8'h76:   r = 8'h0b; // v
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/qsed_in_stage.sv
// Input register of the decoder: holds one raw item until the decoder takes it.
module qsed_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_end_i,
  input  logic               take_i,
  output qsed_pkg::item_t    item_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;

  // Stall only when full and the held item cannot move on.
  assign in_stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_byte_i;
      last_q <= in_end_i;
    end
  end

  assign item_o = '{valid: valid_q, data: data_q, last: last_q};

endmodule

>>> rtl/core/qsed_decode.sv
// Escape decoder: mode/nibble state and the per-item decode logic.
module qsed_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qsed_pkg::item_t    item_i,
  input  logic               take_i,
  output qsed_pkg::res_t     res_o
);

  qsed_pkg::mode_e mode_q, mode_d;
  logic [3:0]      nib_q, nib_d;
  logic            bad_q, bad_d;
  logic [4:0]      hv;
  qsed_pkg::res_t  res;

  assign hv = qsed_pkg::hex_value(item_i.data);

  always_comb begin
    mode_d = mode_q;
    nib_d  = nib_q;
    bad_d  = bad_q;
    res    = '{valid: 1'b0, data: 8'h00, status: qsed_pkg::ST_BYTE};
    if (item_i.last) begin
      res.valid  = 1'b1;
      res.status = (mode_q == qsed_pkg::MODE_HEX1 || mode_q == qsed_pkg::MODE_HEX2) ?
                   qsed_pkg::ST_BADHEX : qsed_pkg::ST_PREMAT;
    end else begin
      case (mode_q)
        qsed_pkg::MODE_PLAIN: begin
          if (item_i.data == qsed_pkg::ChQuote) begin
            res.valid  = 1'b1;
            res.status = qsed_pkg::ST_CLOSED;
          end else if (item_i.data == qsed_pkg::ChBackslash) begin
            mode_d = qsed_pkg::MODE_ESC;
          end else begin
            res.valid = 1'b1;
            res.data  = item_i.data;
          end
        end
        qsed_pkg::MODE_ESC: begin
          if (item_i.data == qsed_pkg::ChLowerX || item_i.data == qsed_pkg::ChUpperX) begin
            mode_d = qsed_pkg::MODE_HEX1;
          end else begin
            mode_d    = qsed_pkg::MODE_PLAIN;
            res.valid = 1'b1;
            res.data  = qsed_pkg::escape_map(item_i.data);
          end
        end
        qsed_pkg::MODE_HEX1: begin
          mode_d = qsed_pkg::MODE_HEX2;
          bad_d  = hv[4];
          nib_d  = hv[4] ? 4'h0 : hv[3:0];
        end
        default: begin
          res.valid = 1'b1;
          if (bad_q || hv[4]) begin
            res.status = qsed_pkg::ST_BADHEX;
          end else begin
            res.data = {nib_q, hv[3:0]};
          end
          mode_d = qsed_pkg::MODE_PLAIN;
          nib_d  = 4'h0;
          bad_d  = 1'b0;
        end
      endcase
    end
    // Any end or error puts the decoder back at the start of a string.
    if (res.valid && res.status != qsed_pkg::ST_BYTE) begin
      mode_d = qsed_pkg::MODE_PLAIN;
      nib_d  = 4'h0;
      bad_d  = 1'b0;
    end
    res.valid = res.valid && item_i.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qsed_pkg::MODE_PLAIN;
      nib_q  <= 4'h0;
      bad_q  <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      nib_q  <= nib_d;
      bad_q  <= bad_d;
    end
  end

  assign res_o = res;

endmodule

>>> rtl/core/qsed_out_stage.sv
// Output register of the decoder: holds one result until the sink takes it.
module qsed_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qsed_pkg::res_t     res_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         out_status_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic [1:0] status_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_i.valid) begin
      data_q   <= res_i.data;
      status_q <= res_i.status;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = data_q;
  assign out_status_o = status_q;

endmodule

>>> rtl/core/quoted_string_escape_decoder_top.sv
// A taken item is decoded combinationally; its result loads into the output register.
// Throughput: one byte per cycle unless stalled; mode state updates once per byte decoded.
// Stalls: input register, decode logic, output register; the stall chain runs back
//   from out_stall_i through both registers, so a full pipe holds two items.
// Reset (rst_ni low, async): registers empty, decoder in plain mode, no pending escape.
module quoted_string_escape_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_status_o
);

  // Item in the input register, and the decoded result headed for the output.
  qsed_pkg::item_t item;
  qsed_pkg::res_t  res;

  // Output register can load this cycle: the held item is decoded and
  // leaves the input register, whether or not it yields a result.
  logic out_ready;
  logic take;

  assign take = item.valid && out_ready;

  qsed_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_end_i   (in_end_i),
    .take_i     (take),
    .item_o     (item)
  );

  // Decode state only advances on a taken item, so a stall freezes it.
  qsed_decode u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .take_i (take),
    .res_o  (res)
  );

  qsed_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_status_o (out_status_o)
  );

endmodule

>>> rtl/core/qsed_checker.sv
// Port-level checker of the escape decoder, bound to the top level.
`include "assert_macros.svh"

module qsed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       in_end_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] out_status_o
);

  logic       end_taken;
  logic       out_free;
  logic       out_held;
  logic       status_res;
  logic [9:0] out_word;

  assign end_taken  = in_valid_i && !in_stall_o && in_end_i;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign out_held   = out_valid_o && out_stall_i;
  assign status_res = out_valid_o && out_status_o != qsed_pkg::ST_BYTE;
  assign out_word   = {out_byte_o, out_status_o};

  `QSED_ASSERT_NEXT(a_out_hold, out_held, out_valid_o, "result dropped while stalled")
  `QSED_ASSERT_NEXT(a_out_stable, out_held, $stable(out_word), "held result changed")
  `QSED_ASSERT_IMPL(a_zero_byte, status_res, out_byte_o == 8'h00, "byte not zero on status")
  `QSED_ASSERT_NEXT(a_end_reports, $past(end_taken) && out_free, status_res, "end not reported")

endmodule

bind quoted_string_escape_decoder_top qsed_checker u_qsed_checker (.*);
